// ===== rtl/u2fhid_pkg.sv =====
package u2fhid_pkg;

	localparam int INIT_DATA_BYTES = 57;
	localparam int CONT_DATA_BYTES = 59;
	localparam int BUFFER_BYTES    = 8192;
	localparam int NONCE_BYTES     = 8;
	localparam int QUEUE_DEPTH     = 2;

	// received length saturates at BUFFER_BYTES, so it needs one value more
	localparam int RLEN_W = $clog2(BUFFER_BYTES + 1);
	localparam int OFF_W  = 13;
	localparam int SLEN_W = 6;

	localparam logic [31:0] BCAST_CHAN       = 32'hFFFF_FFFF;
	localparam logic [7:0]  CMD_PING         = 8'h81;
	localparam logic [7:0]  CMD_MSG          = 8'h83;
	localparam logic [7:0]  CMD_INIT         = 8'h86;
	localparam logic [7:0]  CMD_WINK         = 8'h88;
	localparam logic [7:0]  CMD_SYNC         = 8'hBC;
	localparam logic [15:0] INIT_REPLY_BYTES = 16'd17;
	localparam logic [15:0] ERR_REPLY_BYTES  = 16'd1;
	localparam logic [7:0]  TIMEOUT_RESET    = 8'd3;

	localparam logic [1:0] PSTATE_IDLE  = 2'd0;
	localparam logic [1:0] PSTATE_RX    = 2'd1;
	localparam logic [1:0] PSTATE_READY = 2'd2;
	localparam logic [1:0] PSTATE_TX    = 2'd3;

	typedef enum logic [1:0] {
		REQ_REPORT     = 2'd0,
		REQ_TICK       = 2'd1,
		REQ_TX_DONE    = 2'd2,
		REQ_RESP_START = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_ERR  = 3'd1,
		KIND_PING = 3'd2,
		KIND_SYNC = 3'd3,
		KIND_INIT = 3'd4,
		KIND_WINK = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ERR_CMD     = 3'd0,
		ERR_LEN     = 3'd1,
		ERR_SEQ     = 3'd2,
		ERR_BUSY    = 3'd3,
		ERR_UNALLOC = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		MODE_IDLE  = 4'b0001,
		MODE_RX    = 4'b0010,
		MODE_READY = 4'b0100,
		MODE_TX    = 4'b1000
	} mode_t;

	typedef struct packed {
		kind_t              kind;
		err_t               err;
		logic [31:0]        chan;
		logic [15:0]        len;
		logic               from_buf;
		logic [31:0]        new_chan;
		logic               st_en;
		logic [OFF_W-1:0]   st_off;
		logic [SLEN_W-1:0]  st_len;
	} res_t;

	// one queue entry: the main result plus an optional leading error
	typedef struct packed {
		logic        has_pre;
		logic [31:0] pre_chan;
		logic [1:0]  pstate;
		res_t        res;
	} entry_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		unique case (m)
			MODE_IDLE:  c = PSTATE_IDLE;
			MODE_RX:    c = PSTATE_RX;
			MODE_READY: c = PSTATE_READY;
			MODE_TX:    c = PSTATE_TX;
			default:    c = PSTATE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/u2f_hid_frame_reassembler.sv =====
// U2F HID transport framing control.
// Slave stream: one transfer per report header or event. tuser carries the
// request type (report, one-second tick, transmit complete, response started);
// tdata carries channel, type byte and byte count.
// Master stream: one transfer per result, tlast on the final result of an
// input. tuser is the response kind; tdata holds the error code, response
// channel and length, buffer source flag, new channel, buffer write enable,
// offset and length, message-ready and the protocol state after the input.
// The cfg channel writes the receive timeout in seconds; it is always ready.
// Each result is registered in the result queue; the master side shows the queue head.
// Throughput: one input per cycle while the queue has room; a report from an
// unallocated channel produces two results, the error first, from one queue entry.
// The state update sits in the front stage; a small result queue sits between
// it and the output stage, so inputs keep flowing while the queue has room.
// s_tready drops only when the queue fills, which master backpressure or
// reports that produce two results can bring about.
// Reset clears the state to idle, channel counter to zero, timeout to 3 s.
module u2f_hid_frame_reassembler #(
	parameter int QUEUE_DEPTH = u2fhid_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [1:0]    s_tuser,   // req_type
	input  logic [55:0]   s_tdata,   // channel, type_byte, byte_count
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_data,  // timeout_seconds
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [2:0]    m_tuser,   // resp_kind
	// err_code, resp_channel, resp_length, resp_from_buffer, new_channel,
	// store_en, store_offset, store_len, message_ready, proto_state, pad
	output logic [111:0]  m_tdata,
	output logic          m_tlast
);
	import u2fhid_pkg::*;

	logic    queue_full;
	logic    push;
	entry_t  push_entry;
	logic    pop;
	logic    head_valid;
	entry_t  head_entry;

	assign cfg_ready = 1'b1;

	u2fhid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push),
		.entry      (push_entry)
	);

	u2fhid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	u2fhid_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	// a leading result is always the unallocated-channel error
	a_pre_is_unalloc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == KIND_ERR && m_tdata[2:0] == ERR_UNALLOC)
		else $error("leading result is not an unallocated-channel error");

	a_msg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[104] == (m_tdata[106:105] == PSTATE_READY))
		else $error("message_ready disagrees with protocol state");

	a_store_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[84] |-> m_tdata[103:85] == '0)
		else $error("buffer write fields set without store enable");

	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("result lost after a leading error");

endmodule

// ===== rtl/u2fhid_front.sv =====
module u2fhid_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          s_tuser,
	input  logic [55:0]         s_tdata,
	input  logic                cfg_valid,
	input  logic [7:0]          cfg_data,
	input  logic                queue_full,
	output logic                push,
	output u2fhid_pkg::entry_t  entry
);
	import u2fhid_pkg::*;

	mode_t              mode_q, mode_d;
	logic [31:0]        last_alloc_q, last_alloc_d;
	logic [31:0]        active_q, active_d;
	logic [7:0]         cmd_q, cmd_d;
	logic [7:0]         tl_q, tl_d;
	logic [15:0]        exp_q, exp_d;
	logic [RLEN_W-1:0]  rl_q, rl_d;
	logic [6:0]         seq_q, seq_d;
	logic [7:0]         timeout_q;

	req_t               req;
	logic [31:0]        chan;
	logic [7:0]         tb;
	logic [15:0]        bc;
	logic               is_init;
	logic               clr;
	logic               to_tx;
	logic [RLEN_W:0]    room;
	logic [RLEN_W:0]    rl_sum;
	logic [RLEN_W-1:0]  rl_new;
	entry_t             ent;

	localparam logic [RLEN_W:0] BUF_W  = (RLEN_W + 1)'(BUFFER_BYTES);
	localparam logic [RLEN_W:0] CONT_W = (RLEN_W + 1)'(CONT_DATA_BYTES);

	function automatic res_t with_err(input res_t r, input logic [31:0] ch, input err_t code);
		res_t o;
		o      = r;
		o.kind = KIND_ERR;
		o.err  = code;
		o.chan = ch;
		o.len  = ERR_REPLY_BYTES;
		return o;
	endfunction

	assign req     = req_t'(s_tuser);
	assign chan    = s_tdata[31:0];
	assign tb      = s_tdata[39:32];
	assign bc      = s_tdata[55:40];
	assign is_init = tb[7];

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;
	assign entry    = ent;

	// continuation arithmetic
	assign room   = BUF_W - {1'b0, rl_q};
	assign rl_sum = {1'b0, rl_q} + CONT_W;
	assign rl_new = (rl_sum > BUF_W) ? BUF_W[RLEN_W-1:0] : rl_sum[RLEN_W-1:0];

	always_comb begin
		mode_d       = mode_q;
		last_alloc_d = last_alloc_q;
		active_d     = active_q;
		cmd_d        = cmd_q;
		tl_d         = tl_q;
		exp_d        = exp_q;
		rl_d         = rl_q;
		seq_d        = seq_q;
		clr          = 1'b0;
		to_tx        = 1'b0;
		ent          = '0;

		unique case (req)
			REQ_REPORT: begin
				if (chan != BCAST_CHAN && chan > last_alloc_q) begin
					ent.has_pre  = 1'b1;
					ent.pre_chan = chan;
				end
				if (mode_q == MODE_IDLE) begin
					if (is_init) begin
						active_d = chan;
						unique case (tb)
							CMD_PING: begin
								cmd_d = tb;
								if (bc <= 16'(INIT_DATA_BYTES)) begin
									ent.res.kind = KIND_PING;
									ent.res.chan = chan;
									ent.res.len  = bc;
									mode_d       = MODE_TX;
								end else begin
									ent.res.st_en  = 1'b1;
									ent.res.st_len = SLEN_W'(INIT_DATA_BYTES);
									exp_d  = bc;
									rl_d   = RLEN_W'(INIT_DATA_BYTES);
									seq_d  = '0;
									tl_d   = timeout_q + 8'd1;
									mode_d = MODE_RX;
								end
							end
							CMD_MSG: begin
								cmd_d          = tb;
								ent.res.st_en  = 1'b1;
								ent.res.st_len = SLEN_W'(INIT_DATA_BYTES);
								exp_d          = bc;
								rl_d           = RLEN_W'(INIT_DATA_BYTES);
								if (bc <= 16'(INIT_DATA_BYTES)) begin
									mode_d = MODE_READY;
								end else begin
									seq_d  = '0;
									tl_d   = timeout_q + 8'd1;
									mode_d = MODE_RX;
								end
							end
							CMD_INIT: begin
								if (chan != BCAST_CHAN) begin
									ent.res = with_err(ent.res, chan, ERR_CMD);
								end else if (bc == 16'(NONCE_BYTES)) begin
									last_alloc_d      = last_alloc_q + 32'd1;
									ent.res.st_en     = 1'b1;
									ent.res.st_len    = SLEN_W'(NONCE_BYTES);
									ent.res.kind      = KIND_INIT;
									ent.res.chan      = chan;
									ent.res.len       = INIT_REPLY_BYTES;
									ent.res.from_buf  = 1'b1;
									ent.res.new_chan  = last_alloc_q + 32'd1;
									mode_d            = MODE_TX;
								end else begin
									ent.res = with_err(ent.res, chan, ERR_LEN);
								end
							end
							CMD_WINK: begin
								ent.res.kind = KIND_WINK;
								ent.res.chan = chan;
								mode_d       = MODE_TX;
							end
							default: begin
								ent.res = with_err(ent.res, chan, ERR_CMD);
								mode_d  = MODE_TX;
							end
						endcase
					end
				end else if (chan != active_q) begin
					ent.res = with_err(ent.res, chan, ERR_BUSY);
				end else if (mode_q == MODE_RX) begin
					if (!is_init) begin
						if (tb[6:0] != seq_q) begin
							ent.res = with_err(ent.res, chan, ERR_SEQ);
							clr     = 1'b1;
						end else begin
							if (rl_q < BUF_W[RLEN_W-1:0]) begin
								ent.res.st_en  = 1'b1;
								ent.res.st_off = rl_q[OFF_W-1:0];
								ent.res.st_len = (room < CONT_W) ? room[SLEN_W-1:0]
									: SLEN_W'(CONT_DATA_BYTES);
							end
							rl_d  = rl_new;
							seq_d = seq_q + 7'd1;
							if (16'(rl_new) >= exp_q) begin
								if (cmd_q == CMD_PING) begin
									ent.res.kind     = KIND_PING;
									ent.res.chan     = active_q;
									ent.res.len      = exp_q;
									ent.res.from_buf = 1'b1;
									mode_d           = MODE_TX;
								end else if (cmd_q == CMD_MSG) begin
									mode_d = MODE_READY;
								end else begin
									ent.res = with_err(ent.res, active_q, ERR_CMD);
									clr     = 1'b1;
								end
							end
						end
					end else if (tb == CMD_SYNC) begin
						clr          = 1'b1;
						ent.res.kind = KIND_SYNC;
						ent.res.chan = chan;
					end else begin
						clr     = 1'b1;
						ent.res = with_err(ent.res, chan, ERR_SEQ);
					end
				end else begin
					clr = 1'b1;
					if (tb == CMD_SYNC) begin
						ent.res.kind = KIND_SYNC;
						ent.res.chan = chan;
						to_tx        = 1'b1;
					end else begin
						ent.res = with_err(ent.res, chan, ERR_SEQ);
					end
				end
			end
			REQ_TICK: begin
				if (mode_q == MODE_RX && tl_q != 8'd0) begin
					tl_d = tl_q - 8'd1;
					if (tl_q == 8'd1) begin
						clr = 1'b1;
					end
				end
			end
			REQ_TX_DONE: begin
				clr = 1'b1;
			end
			REQ_RESP_START: begin
				to_tx = 1'b1;
			end
		endcase

		if (clr) begin
			rl_d     = '0;
			seq_d    = '0;
			exp_d    = '0;
			active_d = '0;
			mode_d   = MODE_IDLE;
		end
		if (to_tx) begin
			mode_d = MODE_TX;
		end
		ent.pstate = mode_code(mode_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			last_alloc_q <= '0;
			active_q     <= '0;
			cmd_q        <= '0;
			tl_q         <= '0;
			exp_q        <= '0;
			rl_q         <= '0;
			seq_q        <= '0;
			timeout_q    <= TIMEOUT_RESET;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (push) begin
				mode_q       <= mode_d;
				last_alloc_q <= last_alloc_d;
				active_q     <= active_d;
				cmd_q        <= cmd_d;
				tl_q         <= tl_d;
				exp_q        <= exp_d;
				rl_q         <= rl_d;
				seq_q        <= seq_d;
			end
		end
	end

endmodule

// ===== rtl/u2fhid_queue.sv =====
module u2fhid_queue #(
	parameter int DEPTH = u2fhid_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u2fhid_pkg::entry_t  push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output u2fhid_pkg::entry_t  head_entry
);
	import u2fhid_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/u2fhid_back.sv =====
module u2fhid_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  u2fhid_pkg::entry_t  head_entry,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [2:0]          m_tuser,
	output logic [111:0]        m_tdata,
	output logic                m_tlast
);
	import u2fhid_pkg::*;

	logic  pre_sent_q;
	logic  beat_is_pre;
	logic  xfer;
	res_t  r;

	assign beat_is_pre = head_entry.has_pre && !pre_sent_q;
	assign xfer        = m_tvalid && m_tready;
	assign pop         = xfer && !beat_is_pre;

	always_comb begin
		r = head_entry.res;
		if (beat_is_pre) begin
			r      = '0;
			r.kind = KIND_ERR;
			r.err  = ERR_UNALLOC;
			r.chan = head_entry.pre_chan;
			r.len  = ERR_REPLY_BYTES;
		end
	end

	assign m_tvalid = head_valid;
	assign m_tlast  = !beat_is_pre;
	assign m_tuser  = r.kind;
	assign m_tdata  = {5'b0, head_entry.pstate, head_entry.pstate == PSTATE_READY,
		r.st_len, r.st_off, r.st_en, r.new_chan, r.from_buf, r.len, r.chan, r.err};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_sent_q <= 1'b0;
		end else if (xfer) begin
			pre_sent_q <= beat_is_pre;
		end
	end

endmodule

// ===== sim/u2f_hid_frame_reassembler_test.sv =====
`timescale 1ns / 1ps

module u2f_hid_frame_reassembler_test;
	import u2fhid_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 80;

	typedef struct packed {
		kind_t             kind;
		err_t              err;
		logic [31:0]       chan;
		logic [15:0]       len;
		logic              from_buf;
		logic [31:0]       newch;
		logic              st_en;
		logic [OFF_W-1:0]  st_off;
		logic [SLEN_W-1:0] st_len;
		logic              msg_ready;
		logic [1:0]        pstate;
		logic              last;
	} hid_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [1:0]    s_tuser = '0;
	logic [55:0]   s_tdata = '0;   // channel, type_byte, byte_count
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [7:0]    cfg_data = '0;  // timeout_seconds
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [2:0]    m_tuser;        // resp_kind
	// err_code, resp_channel, resp_length, resp_from_buffer, new_channel,
	// store_en, store_offset, store_len, message_ready, proto_state, pad
	logic [111:0]  m_tdata;
	logic          m_tlast;

	// framing state as the block should hold it
	logic [1:0]        st_mode = PSTATE_IDLE;
	logic [31:0]       alloc_last = '0;
	logic [31:0]       act_chan = '0;
	logic [7:0]        cur_cmd = '0;
	logic [7:0]        tmo_left = '0;
	logic [7:0]        tmo_cfg = TIMEOUT_RESET;
	logic [15:0]       exp_len = '0;
	logic [RLEN_W-1:0] rx_len = '0;
	logic [6:0]        seq_next = '0;

	hid_result_t pending_replies[$];
	int          fail_count = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	bit          no_gaps = 1'b0;
	bit          hold_req = 1'b0;

	u2f_hid_frame_reassembler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------- framing predictor ----------------

	function automatic void mark_error(inout hid_result_t r, input logic [31:0] ch,
			input err_t code);
		r.kind = KIND_ERR;
		r.err  = code;
		r.chan = ch;
		r.len  = ERR_REPLY_BYTES;
	endfunction

	function automatic void mark_store(inout hid_result_t r, input int off, input int len);
		r.st_en  = 1'b1;
		r.st_off = 13'(off);
		r.st_len = 6'(len);
	endfunction

	function automatic void drop_receive();
		rx_len   = '0;
		seq_next = '0;
		exp_len  = '0;
		act_chan = '0;
		st_mode  = PSTATE_IDLE;
	endfunction

	function automatic void open_receive(input logic [15:0] bc);
		exp_len  = bc;
		rx_len   = RLEN_W'(INIT_DATA_BYTES);
		seq_next = '0;
		tmo_left = tmo_cfg + 8'd1;  // 255 wraps to 0: never times out
		st_mode  = PSTATE_RX;
	endfunction

	function automatic void take_continuation(inout hid_result_t r, input logic [31:0] ch,
			input logic [7:0] tb);
		int room;
		if (tb[6:0] != seq_next) begin
			mark_error(r, ch, ERR_SEQ);
			drop_receive();
			return;
		end
		if (int'(rx_len) < BUFFER_BYTES) begin
			room = BUFFER_BYTES - int'(rx_len);
			mark_store(r, int'(rx_len), room < CONT_DATA_BYTES ? room : CONT_DATA_BYTES);
		end
		if (int'(rx_len) + CONT_DATA_BYTES > BUFFER_BYTES)
			rx_len = RLEN_W'(BUFFER_BYTES);
		else
			rx_len = rx_len + RLEN_W'(CONT_DATA_BYTES);
		seq_next = seq_next + 7'd1;
		if (32'(rx_len) >= 32'(exp_len)) begin
			if (cur_cmd == CMD_PING) begin
				r.kind     = KIND_PING;
				r.chan     = act_chan;
				r.len      = exp_len;
				r.from_buf = 1'b1;
				st_mode    = PSTATE_TX;
			end else if (cur_cmd == CMD_MSG) begin
				st_mode = PSTATE_READY;
			end else begin
				mark_error(r, act_chan, ERR_CMD);
				drop_receive();
			end
		end
	endfunction

	function automatic void take_init(inout hid_result_t r, input logic [31:0] ch,
			input logic [7:0] tb, input logic [15:0] bc);
		act_chan = ch;
		case (tb)
			CMD_PING: begin
				if (int'(bc) <= INIT_DATA_BYTES) begin
					r.kind  = KIND_PING;
					r.chan  = act_chan;
					r.len   = bc;
					st_mode = PSTATE_TX;
				end else begin
					mark_store(r, 0, INIT_DATA_BYTES);
					open_receive(bc);
				end
				cur_cmd = tb;
			end
			CMD_MSG: begin
				mark_store(r, 0, INIT_DATA_BYTES);
				if (int'(bc) <= INIT_DATA_BYTES) begin
					exp_len = bc;
					rx_len  = RLEN_W'(INIT_DATA_BYTES);
					st_mode = PSTATE_READY;
				end else begin
					open_receive(bc);
				end
				cur_cmd = tb;
			end
			CMD_INIT: begin
				if (ch != BCAST_CHAN) begin
					mark_error(r, ch, ERR_CMD);
				end else if (int'(bc) == NONCE_BYTES) begin
					mark_store(r, 0, NONCE_BYTES);
					alloc_last = alloc_last + 32'd1;
					r.kind     = KIND_INIT;
					r.chan     = act_chan;
					r.len      = INIT_REPLY_BYTES;
					r.from_buf = 1'b1;
					r.newch    = alloc_last;
					st_mode    = PSTATE_TX;
				end else begin
					mark_error(r, ch, ERR_LEN);
				end
			end
			CMD_WINK: begin
				r.kind  = KIND_WINK;
				r.chan  = act_chan;
				r.len   = '0;
				st_mode = PSTATE_TX;
			end
			default: begin
				st_mode = PSTATE_TX;
				mark_error(r, ch, ERR_CMD);
			end
		endcase
	endfunction

	function automatic void take_report(inout hid_result_t r, input logic [31:0] ch,
			input logic [7:0] tb, input logic [15:0] bc);
		if (st_mode == PSTATE_IDLE) begin
			// a continuation with nothing in progress is simply dropped
			if (tb[7])
				take_init(r, ch, tb, bc);
			return;
		end
		if (ch != act_chan) begin
			mark_error(r, ch, ERR_BUSY);
			return;
		end
		if (st_mode == PSTATE_RX && !tb[7]) begin
			take_continuation(r, ch, tb);
		end else if (tb == CMD_SYNC) begin
			drop_receive();
			r.kind = KIND_SYNC;
			r.chan = ch;
		end else begin
			drop_receive();
			mark_error(r, ch, ERR_SEQ);
		end
	endfunction

	function automatic void predict_framing(input req_t req, input logic [31:0] ch,
			input logic [7:0] tb, input logic [15:0] bc);
		hid_result_t lead_err;
		hid_result_t reply;
		bit          two;
		bit          was_rx;
		lead_err = '0;
		reply    = '0;
		two      = 1'b0;
		was_rx   = (st_mode == PSTATE_RX);
		case (req)
			REQ_REPORT: begin
				if (ch != BCAST_CHAN && ch > alloc_last) begin
					mark_error(lead_err, ch, ERR_UNALLOC);
					two = 1'b1;
				end
				take_report(reply, ch, tb, bc);
				// sync from ready or transmit answers and stays in transmit
				if (!was_rx && reply.kind == KIND_SYNC)
					st_mode = PSTATE_TX;
			end
			REQ_TICK: begin
				if (st_mode == PSTATE_RX && tmo_left != 8'd0) begin
					tmo_left = tmo_left - 8'd1;
					if (tmo_left == 8'd0)
						drop_receive();
				end
			end
			REQ_TX_DONE: drop_receive();
			default: st_mode = PSTATE_TX;
		endcase
		lead_err.pstate    = st_mode;
		lead_err.msg_ready = (st_mode == PSTATE_READY);
		reply.pstate       = st_mode;
		reply.msg_ready    = (st_mode == PSTATE_READY);
		reply.last         = 1'b1;
		if (two)
			pending_replies.push_back(lead_err);
		pending_replies.push_back(reply);
	endfunction

	// ---------------- checking ----------------

	function automatic string fmt_result(input hid_result_t r);
		return $sformatf({"kind=%0d err=%0d ch=%h len=%0d buf=%b new=%h st=%b/%0d/%0d",
			" rdy=%b state=%0d last=%b"}, r.kind, r.err, r.chan, r.len, r.from_buf,
			r.newch, r.st_en, r.st_off, r.st_len, r.msg_ready, r.pstate, r.last);
	endfunction

	function automatic string diff_fields(input hid_result_t w, input hid_result_t g);
		string s;
		s = "";
		if (w.kind !== g.kind)           s = {s, " resp_kind"};
		if (w.err !== g.err)             s = {s, " err_code"};
		if (w.chan !== g.chan)           s = {s, " resp_channel"};
		if (w.len !== g.len)             s = {s, " resp_length"};
		if (w.from_buf !== g.from_buf)   s = {s, " resp_from_buffer"};
		if (w.newch !== g.newch)         s = {s, " new_channel"};
		if (w.st_en !== g.st_en)         s = {s, " store_en"};
		if (w.st_off !== g.st_off)       s = {s, " store_offset"};
		if (w.st_len !== g.st_len)       s = {s, " store_len"};
		if (w.msg_ready !== g.msg_ready) s = {s, " message_ready"};
		if (w.pstate !== g.pstate)       s = {s, " proto_state"};
		if (w.last !== g.last)           s = {s, " last"};
		return s;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : check_output
		hid_result_t got;
		hid_result_t want;
		string       bad;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got.kind      = kind_t'(m_tuser);
			got.err       = err_t'(m_tdata[2:0]);
			got.chan      = m_tdata[34:3];
			got.len       = m_tdata[50:35];
			got.from_buf  = m_tdata[51];
			got.newch     = m_tdata[83:52];
			got.st_en     = m_tdata[84];
			got.st_off    = m_tdata[97:85];
			got.st_len    = m_tdata[103:98];
			got.msg_ready = m_tdata[104];
			got.pstate    = m_tdata[106:105];
			got.last      = m_tlast;
			if (pending_replies.size() == 0) begin
				note_failure({"unexpected result: ", fmt_result(got)});
			end else begin
				want = pending_replies.pop_front();
				bad  = diff_fields(want, got);
				if (bad != "")
					note_failure({"mismatch in", bad, "\n  expected ", fmt_result(want),
						"\n  actual   ", fmt_result(got)});
			end
		end
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_gaps || ($urandom_range(99) >= 22);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("u2f_hid_frame_reassembler test failed");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_item(input req_t req, input logic [31:0] ch, input logic [7:0] tb,
			input logic [15:0] bc);
		while (!no_gaps && $urandom_range(99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {bc, tb, ch};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		predict_framing(req, ch, tb, bc);
		items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [7:0] secs);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= secs;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		tmo_cfg = secs;
	endtask

	task automatic finish_exchange();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			send_item(REQ_REPORT, act_chan, CMD_SYNC, 16'($urandom));
		else if (roll < 35)
			send_item(REQ_RESP_START, $urandom, 8'($urandom), 16'($urandom));
		send_item(REQ_TX_DONE, $urandom, 8'($urandom), 16'($urandom));
	endtask

	// one well-formed exchange with random content and the odd fault mixed in
	task automatic run_exchange();
		logic [31:0] ch;
		logic [7:0]  cmd;
		logic [15:0] len;
		int          roll;
		int          steps;
		if (st_mode != PSTATE_IDLE)
			send_item(REQ_TX_DONE, $urandom, 8'($urandom), 16'($urandom));
		roll = $urandom_range(99);
		if (alloc_last < 32'd4 || roll < 8) begin
			send_item(REQ_REPORT, BCAST_CHAN, CMD_INIT, 16'(NONCE_BYTES));
			finish_exchange();
			return;
		end
		if (roll < 16)
			ch = BCAST_CHAN;
		else if (roll < 20)
			ch = alloc_last + 32'($urandom_range(4, 1));
		else
			ch = 32'($urandom_range(alloc_last - 32'd1)) + 32'd1;
		roll = $urandom_range(99);
		cmd  = roll < 40 ? CMD_PING : roll < 85 ? CMD_MSG : roll < 95 ? CMD_WINK : CMD_SYNC;
		roll = $urandom_range(99);
		len  = roll < 70 ? 16'($urandom_range(120)) :
		       roll < 95 ? 16'($urandom_range(700)) : 16'($urandom);
		send_item(REQ_REPORT, ch, cmd, len);
		steps = 0;
		while (st_mode == PSTATE_RX && steps < 20) begin
			roll = $urandom_range(99);
			if (roll < 5)
				send_item(REQ_TICK, $urandom, 8'($urandom), 16'($urandom));
			else if (roll < 8)
				send_item(REQ_REPORT, ch, {1'b0, seq_next + 7'($urandom_range(127, 1))},
					16'($urandom));
			else if (roll < 10)
				send_item(REQ_REPORT, ch + 32'd1, {1'b0, seq_next}, 16'($urandom));
			else
				send_item(REQ_REPORT, ch, {1'b0, seq_next}, 16'($urandom));
			steps++;
		end
		finish_exchange();
	endtask

	task automatic send_noise();
		logic [31:0] ch;
		int          roll;
		roll = $urandom_range(3);
		ch   = roll == 0 ? $urandom : roll == 1 ? BCAST_CHAN :
		       roll == 2 ? 32'($urandom_range(alloc_last)) : act_chan;
		send_item(req_t'($urandom_range(3)), ch, 8'($urandom), 16'($urandom));
	endtask

	// ---------------- tests ----------------

	task automatic test_commands();
		send_item(REQ_TICK, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd0, 8'h05, 16'hFFFF);         // continuation while idle
		send_item(REQ_REPORT, 32'd0, CMD_INIT, 16'd8);          // init off broadcast
		send_item(REQ_REPORT, BCAST_CHAN, CMD_INIT, 16'hFFFF);  // bad nonce length
		send_item(REQ_REPORT, BCAST_CHAN, CMD_INIT, 16'(NONCE_BYTES));
		send_item(REQ_TX_DONE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
		send_item(REQ_REPORT, BCAST_CHAN, CMD_INIT, 16'(NONCE_BYTES));
		send_item(REQ_RESP_START, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd1, CMD_PING, 16'd0);
		send_item(REQ_REPORT, 32'd2, CMD_PING, 16'd0);          // busy
		send_item(REQ_REPORT, 32'hFFFF_FFFE, CMD_WINK, 16'd0);  // unallocated and busy
		send_item(REQ_REPORT, 32'd1, CMD_SYNC, 16'd0);          // sync outside receive
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd2, CMD_PING, 16'(INIT_DATA_BYTES));
		send_item(REQ_REPORT, 32'd2, CMD_MSG, 16'd0);           // new init while sending
		send_item(REQ_REPORT, 32'd1, CMD_WINK, 16'd0);
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd1, 8'hFF, 16'hFFFF);          // unknown command
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd2, CMD_MSG, 16'(INIT_DATA_BYTES));
		send_item(REQ_RESP_START, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd7, CMD_PING, 16'd0);          // unallocated channel
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
	endtask

	task automatic test_receive_paths();
		send_item(REQ_REPORT, 32'd1, CMD_PING, 16'd100);
		send_item(REQ_REPORT, 32'd1, 8'h03, 16'd0);             // wrong sequence
		send_item(REQ_REPORT, 32'd1, CMD_PING, 16'd100);
		send_item(REQ_REPORT, 32'd2, 8'h00, 16'd0);             // other channel
		send_item(REQ_REPORT, 32'd1, CMD_MSG, 16'd10);          // init mid-receive
		send_item(REQ_REPORT, 32'd1, CMD_PING, 16'd116);
		send_item(REQ_REPORT, 32'd1, 8'h00, 16'hFFFF);
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, BCAST_CHAN, CMD_MSG, 16'd58);
		send_item(REQ_REPORT, BCAST_CHAN, 8'h00, 16'd0);
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd2, CMD_MSG, 16'd200);
		send_item(REQ_REPORT, 32'd2, CMD_SYNC, 16'd0);          // sync in receive
		send_item(REQ_REPORT, 32'd2, CMD_MSG, 16'd177);
		send_item(REQ_REPORT, 32'd2, 8'h00, 16'd0);
		send_item(REQ_REPORT, 32'd2, 8'h01, 16'd0);
		send_item(REQ_REPORT, 32'd2, 8'h02, 16'd0);
		send_item(REQ_REPORT, 32'd2, 8'h03, 16'd0);             // after message ready
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
	endtask

	task automatic test_receive_timeout();
		write_timeout(8'd0);
		send_item(REQ_REPORT, 32'd1, CMD_MSG, 16'd300);
		send_item(REQ_TICK, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd1, 8'h00, 16'd0);
		write_timeout(8'd255);                                  // never times out
		send_item(REQ_REPORT, 32'd1, CMD_MSG, 16'd300);
		repeat (3) send_item(REQ_TICK, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd1, 8'h00, 16'd0);
		send_item(REQ_REPORT, 32'd1, CMD_SYNC, 16'd0);
		write_timeout(8'd254);
		send_item(REQ_REPORT, 32'd1, CMD_PING, 16'd130);
		repeat (2) send_item(REQ_TICK, 32'd0, 8'h00, 16'h0000);
		send_item(REQ_REPORT, 32'd1, 8'h00, 16'd0);
		send_item(REQ_REPORT, 32'd1, 8'h01, 16'd0);
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
		write_timeout(TIMEOUT_RESET);
		send_item(REQ_REPORT, 32'd1, CMD_MSG, 16'd500);
		repeat (4) send_item(REQ_TICK, 32'd0, 8'h00, 16'h0000);
	endtask

	// longest message: fills the buffer, wraps the sequence, never completes
	task automatic test_buffer_overflow();
		int i;
		send_item(REQ_REPORT, 32'd1, CMD_MSG, 16'hFFFF);
		for (i = 0; i < 145; i++)
			send_item(REQ_REPORT, 32'd1, {1'b0, seq_next}, 16'($urandom));
		send_item(REQ_TX_DONE, 32'd0, 8'h00, 16'h0000);
	endtask

	task automatic test_output_stall();
		int i;
		drain_results();
		no_gaps  = 1'b1;
		hold_req = 1'b1;
		for (i = 0; i < 30; i++) begin
			if (i % 3 == 0)
				send_item(REQ_REPORT, alloc_last + 32'd7, CMD_WINK, 16'd0);
			else
				send_item(REQ_TX_DONE, $urandom, 8'($urandom), 16'($urandom));
		end
		drain_results();
		no_gaps = 1'b0;
	endtask

	task automatic test_random_traffic();
		int          phase;
		int          target;
		logic [7:0]  secs;
		for (phase = 0; phase < 4; phase++) begin
			secs = phase == 0 ? 8'd0 : phase == 1 ? 8'd255 : phase == 2 ? 8'd1 :
			       8'($urandom_range(254, 2));
			write_timeout(secs);
			no_gaps = (phase == 2);
			target  = items_sent + 210;
			while (items_sent < target) begin
				if ($urandom_range(99) < 75)
					run_exchange();
				else
					send_noise();
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_receive_paths();
		test_receive_timeout();
		test_buffer_overflow();
		test_output_stall();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		if (pending_replies.size() != 0)
			note_failure($sformatf("%0d expected results never arrived",
				pending_replies.size()));
		if (fail_count == 0)
			$display("u2f_hid_frame_reassembler test passed");
		else
			$display("u2f_hid_frame_reassembler test failed");
		$finish;
	end

endmodule
